[src/tpst_pkg.sv]
`default_nettype none
package tpst_pkg;

	localparam int CW    = 24;          // coordinate width
	localparam int F     = 24;          // coefficient fraction bits
	localparam int DW    = CW + 1;      // point difference
	localparam int PW    = 2 * DW;      // difference product
	localparam int MW    = 2 * CW + 1;  // magnitude of |u|^2, u.v, u x v
	localparam int NUM_W = MW + F + 1;  // dividend, one cell per bit
	localparam int OW    = 32;          // output word
	localparam int TW    = OW + CW;     // coefficient times coordinate
	localparam int SW    = TW + 2;      // translation sum

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [MW-1:0]    rem;
		logic [OW-1:0]    quo;
		logic             ovf;
		logic             neg;
	} lane_t;

	typedef struct packed {
		logic                 vld;
		logic                 coinc;
		logic signed [CW-1:0] p1x;
		logic signed [CW-1:0] p1y;
		logic signed [CW-1:0] q1x;
		logic signed [CW-1:0] q1y;
		logic [MW-1:0]        den;
		lane_t                a;
		lane_t                b;
	} cell_t;

endpackage
`default_nettype wire

[src/tpst_div_cell.sv]
`default_nettype none
module tpst_div_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire tpst_pkg::cell_t d,
	output tpst_pkg::cell_t      q
);

	function automatic tpst_pkg::lane_t div_step(tpst_pkg::lane_t l,
			logic [tpst_pkg::MW-1:0] den);
		logic [tpst_pkg::MW:0] trial;
		logic                  ge;
		tpst_pkg::lane_t       r;
		r     = l;
		trial = {l.rem, l.num[tpst_pkg::NUM_W-1]};
		ge    = (trial >= {1'b0, den});
		r.rem = ge ? tpst_pkg::MW'(trial - {1'b0, den}) : trial[tpst_pkg::MW-1:0];
		r.num = {l.num[tpst_pkg::NUM_W-2:0], 1'b0};
		r.quo = {l.quo[tpst_pkg::OW-2:0], ge};
		r.ovf = l.ovf | l.quo[tpst_pkg::OW-1];
		return r;
	endfunction

	tpst_pkg::cell_t nxt;

	always_comb begin
		nxt   = d;
		nxt.a = div_step(d.a, d.den);
		nxt.b = div_step(d.b, d.den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q.vld <= 1'b0;
		end else if (en) begin
			q <= nxt;
		end
	end

endmodule
`default_nettype wire

[src/two_point_similarity_transform_core.sv]
// Two-point similarity transform core.
// Slave stream s_*: one transaction carries two source and two target points,
// eight signed Q15.8 coordinates of 24 bits. Master stream m_*: one
// transaction per input carries scale_cos, scale_sin (Q7.24), shift_x and
// shift_y (Q23.8); m_tuser bit 0 is status (points coincide, data zero),
// bit 1 is saturated (a value was clipped).
// The pipeline has four front stages (input capture, products, sums,
// dividend setup), a chain of 74 divider cells producing one quotient bit
// each for u.v/|u|^2 and u x v/|u|^2 side by side, two stages for
// coefficient clipping and translation products, and the output register.
// Throughput is one transaction per cycle while the output is not stalled;
// the pipeline holds up to 81 items.
// Reset clears all valid flags; the pipeline holds no other state.
// When the receiver stalls with m_tvalid high, the whole pipeline freezes and
// s_tready drops in the same cycle; it resumes as soon as m_tready returns.
`default_nettype none
module two_point_similarity_transform_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// src1_x, src1_y, src2_x, src2_y, dst1_x, dst1_y, dst2_x, dst2_y
	input  wire logic [191:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// scale_cos, scale_sin, shift_x, shift_y
	output logic [127:0]      m_tdata,
	// status, saturated
	output logic [1:0]        m_tuser
);

	localparam int CW = tpst_pkg::CW;
	localparam int F  = tpst_pkg::F;
	localparam int DW = tpst_pkg::DW;
	localparam int PW = tpst_pkg::PW;
	localparam int MW = tpst_pkg::MW;
	localparam int NW = tpst_pkg::NUM_W;
	localparam int OW = tpst_pkg::OW;
	localparam int TW = tpst_pkg::TW;
	localparam int SW = tpst_pkg::SW;

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: input capture
	logic                 vld_s1;
	logic signed [CW-1:0] p1x_s1, p1y_s1, p2x_s1, p2y_s1;
	logic signed [CW-1:0] q1x_s1, q1y_s1, q2x_s1, q2y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			p1x_s1 <= s_tdata[0*CW +: CW];
			p1y_s1 <= s_tdata[1*CW +: CW];
			p2x_s1 <= s_tdata[2*CW +: CW];
			p2y_s1 <= s_tdata[3*CW +: CW];
			q1x_s1 <= s_tdata[4*CW +: CW];
			q1y_s1 <= s_tdata[5*CW +: CW];
			q2x_s1 <= s_tdata[6*CW +: CW];
			q2y_s1 <= s_tdata[7*CW +: CW];
		end
	end

	logic signed [DW-1:0] ux, uy, vx, vy;
	assign ux = DW'(p2x_s1) - DW'(p1x_s1);
	assign uy = DW'(p2y_s1) - DW'(p1y_s1);
	assign vx = DW'(q2x_s1) - DW'(q1x_s1);
	assign vy = DW'(q2y_s1) - DW'(q1y_s1);

	// stage 2: products
	logic                 vld_s2, coinc_s2;
	logic signed [PW-1:0] uxux_s2, uyuy_s2, uxvx_s2, uyvy_s2, uxvy_s2, uyvx_s2;
	logic signed [CW-1:0] p1x_s2, p1y_s2, q1x_s2, q1y_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2   <= vld_s1;
			coinc_s2 <= (ux == '0 && uy == '0) || (vx == '0 && vy == '0);
			uxux_s2  <= PW'(ux) * PW'(ux);
			uyuy_s2  <= PW'(uy) * PW'(uy);
			uxvx_s2  <= PW'(ux) * PW'(vx);
			uyvy_s2  <= PW'(uy) * PW'(vy);
			uxvy_s2  <= PW'(ux) * PW'(vy);
			uyvx_s2  <= PW'(uy) * PW'(vx);
			p1x_s2   <= p1x_s1;
			p1y_s2   <= p1y_s1;
			q1x_s2   <= q1x_s1;
			q1y_s2   <= q1y_s1;
		end
	end

	// stage 3: sums
	logic                 vld_s3, coinc_s3;
	logic signed [PW:0]   n2_s3, dot_s3, crs_s3;
	logic signed [CW-1:0] p1x_s3, p1y_s3, q1x_s3, q1y_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3   <= vld_s2;
			coinc_s3 <= coinc_s2;
			n2_s3    <= (PW+1)'(uxux_s2) + (PW+1)'(uyuy_s2);
			dot_s3   <= (PW+1)'(uxvx_s2) + (PW+1)'(uyvy_s2);
			crs_s3   <= (PW+1)'(uxvy_s2) - (PW+1)'(uyvx_s2);
			p1x_s3   <= p1x_s2;
			p1y_s3   <= p1y_s2;
			q1x_s3   <= q1x_s2;
			q1y_s3   <= q1y_s2;
		end
	end

	// stage 4: dividends with rounding half
	logic signed [PW:0] mag_a, mag_b;
	assign mag_a = dot_s3[PW] ? -dot_s3 : dot_s3;
	assign mag_b = crs_s3[PW] ? -crs_s3 : crs_s3;

	logic                 vld_s4, coinc_s4, neg_a_s4, neg_b_s4;
	logic [MW-1:0]        n2_s4;
	logic [NW-1:0]        num_a_s4, num_b_s4;
	logic signed [CW-1:0] p1x_s4, p1y_s4, q1x_s4, q1y_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4   <= vld_s3;
			coinc_s4 <= coinc_s3;
			neg_a_s4 <= dot_s3[PW];
			neg_b_s4 <= crs_s3[PW];
			n2_s4    <= n2_s3[MW-1:0];
			num_a_s4 <= NW'({mag_a[MW-1:0], {F{1'b0}}}) + NW'(n2_s3[MW-1:1]);
			num_b_s4 <= NW'({mag_b[MW-1:0], {F{1'b0}}}) + NW'(n2_s3[MW-1:1]);
			p1x_s4   <= p1x_s3;
			p1y_s4   <= p1y_s3;
			q1x_s4   <= q1x_s3;
			q1y_s4   <= q1y_s3;
		end
	end

	// divider chain
	tpst_pkg::cell_t chain [NW+1];

	always_comb begin
		chain[0].vld   = vld_s4;
		chain[0].coinc = coinc_s4;
		chain[0].p1x   = p1x_s4;
		chain[0].p1y   = p1y_s4;
		chain[0].q1x   = q1x_s4;
		chain[0].q1y   = q1y_s4;
		chain[0].den   = n2_s4;
		chain[0].a.num = num_a_s4;
		chain[0].a.rem = '0;
		chain[0].a.quo = '0;
		chain[0].a.ovf = 1'b0;
		chain[0].a.neg = neg_a_s4;
		chain[0].b.num = num_b_s4;
		chain[0].b.rem = '0;
		chain[0].b.quo = '0;
		chain[0].b.ovf = 1'b0;
		chain[0].b.neg = neg_b_s4;
	end

	for (genvar k = 0; k < NW; k++) begin : g_cell
		tpst_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d      (chain[k]),
			.q      (chain[k+1])
		);
	end

	// coefficient sign and clip: {clipped, value}
	function automatic logic [OW:0] coef_sat(tpst_pkg::lane_t l);
		logic [OW:0] r;
		if (!l.neg) begin
			if (l.ovf || l.quo[OW-1]) r = {1'b1, 1'b0, {(OW-1){1'b1}}};
			else                      r = {1'b0, l.quo};
		end else begin
			if (!l.ovf && (!l.quo[OW-1] || l.quo[OW-2:0] == '0)) r = {1'b0, -l.quo};
			else                                                  r = {1'b1, 1'b1, {(OW-1){1'b0}}};
		end
		return r;
	endfunction

	tpst_pkg::cell_t last;
	logic [OW:0]     ca, cb;
	assign last = chain[NW];
	assign ca   = coef_sat(last.a);
	assign cb   = coef_sat(last.b);

	// back stage 1: coefficients
	logic                 vld_b1, coinc_b1, sat_b1;
	logic signed [OW-1:0] a_b1, b_b1;
	logic signed [CW-1:0] p1x_b1, p1y_b1, q1x_b1, q1y_b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_b1 <= 1'b0;
		end else if (en) begin
			vld_b1   <= last.vld;
			coinc_b1 <= last.coinc;
			sat_b1   <= ca[OW] | cb[OW];
			a_b1     <= ca[OW-1:0];
			b_b1     <= cb[OW-1:0];
			p1x_b1   <= last.p1x;
			p1y_b1   <= last.p1y;
			q1x_b1   <= last.q1x;
			q1y_b1   <= last.q1y;
		end
	end

	// back stage 2: translation products
	logic                 vld_b2, coinc_b2, sat_b2;
	logic signed [OW-1:0] a_b2, b_b2;
	logic signed [TW-1:0] ap1x_b2, bp1y_b2, bp1x_b2, ap1y_b2;
	logic signed [CW-1:0] q1x_b2, q1y_b2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_b2 <= 1'b0;
		end else if (en) begin
			vld_b2   <= vld_b1;
			coinc_b2 <= coinc_b1;
			sat_b2   <= sat_b1;
			a_b2     <= a_b1;
			b_b2     <= b_b1;
			ap1x_b2  <= TW'(a_b1) * TW'(p1x_b1);
			bp1y_b2  <= TW'(b_b1) * TW'(p1y_b1);
			bp1x_b2  <= TW'(b_b1) * TW'(p1x_b1);
			ap1y_b2  <= TW'(a_b1) * TW'(p1y_b1);
			q1x_b2   <= q1x_b1;
			q1y_b2   <= q1y_b1;
		end
	end

	logic signed [SW-1:0] half, sx, sy, rx, ry;
	logic                 ovx, ovy;
	logic [OW-1:0]        tx, ty;

	assign half = SW'(1) <<< (F - 1);
	assign sx   = (SW'(q1x_b2) <<< F) - SW'(ap1x_b2) + SW'(bp1y_b2) + half;
	assign sy   = (SW'(q1y_b2) <<< F) - SW'(bp1x_b2) - SW'(ap1y_b2) + half;
	assign rx   = sx >>> F;
	assign ry   = sy >>> F;
	assign ovx  = !((&rx[SW-1:OW-1]) || !(|rx[SW-1:OW-1]));
	assign ovy  = !((&ry[SW-1:OW-1]) || !(|ry[SW-1:OW-1]));
	assign tx   = ovx ? {rx[SW-1], {(OW-1){!rx[SW-1]}}} : rx[OW-1:0];
	assign ty   = ovy ? {ry[SW-1], {(OW-1){!ry[SW-1]}}} : ry[OW-1:0];

	// output register
	logic         vld_q;
	logic [127:0] tdata_q;
	logic [1:0]   tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_b2;
			if (coinc_b2) begin
				tdata_q <= '0;
				tuser_q <= 2'b01;
			end else begin
				tdata_q <= {ty, tx, b_b2, a_b2};
				tuser_q <= {sat_b2 | ovx | ovy, 1'b0};
			end
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
		else $error("coincident points with nonzero result");

	a_chain_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		en && last.vld |=> vld_b1)
		else $error("item lost leaving divider chain");

	a_back_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_b2 |=> m_tvalid)
		else $error("item lost at output register");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_b2) && $stable(last.vld))
		else $error("pipeline moved during stall");

endmodule
`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
`default_nettype none
module testbench;

	localparam logic signed [127:0] MAX32 = 128'sd2147483647;
	localparam logic signed [127:0] MIN32 = -128'sd2147483648;
	localparam int STALL_LIMIT = 4000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [191:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b1;
	logic [127:0] m_tdata;
	logic [1:0]   m_tuser;

	logic [129:0] transform_q[$];
	int fails = 0;
	int sent = 0;
	int received = 0;
	int n_coinc = 0;
	int n_sat = 0;
	int idle_cycles = 0;
	bit no_gaps = 0;

	two_point_similarity_transform_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	function automatic logic signed [127:0] clip32(logic signed [127:0] v, inout logic sat);
		if (v > MAX32) begin
			sat = 1'b1;
			return MAX32;
		end
		if (v < MIN32) begin
			sat = 1'b1;
			return MIN32;
		end
		return v;
	endfunction

	function automatic logic signed [127:0] coef_q(logic signed [127:0] num,
			logic signed [127:0] den, inout logic sat);
		logic neg;
		logic signed [127:0] mag, q;
		neg = num < 0;
		mag = neg ? -num : num;
		q = ((mag <<< 24) + (den >>> 1)) / den;
		if (neg) q = -q;
		return clip32(q, sat);
	endfunction

	function automatic logic signed [127:0] round_shift(logic signed [127:0] s,
			inout logic sat);
		return clip32((s + (128'sd1 <<< 23)) >>> 24, sat);
	endfunction

	// {saturated, status, shift_y, shift_x, scale_sin, scale_cos}
	function automatic logic [129:0] predict_transform(logic [191:0] d);
		logic signed [127:0] p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y;
		logic signed [127:0] ux, uy, vx, vy, n2, dt, cr, a, b, tx, ty;
		logic sat;
		p1x = $signed(d[23:0]);    p1y = $signed(d[47:24]);
		p2x = $signed(d[71:48]);   p2y = $signed(d[95:72]);
		q1x = $signed(d[119:96]);  q1y = $signed(d[143:120]);
		q2x = $signed(d[167:144]); q2y = $signed(d[191:168]);
		ux = p2x - p1x; uy = p2y - p1y;
		vx = q2x - q1x; vy = q2y - q1y;
		if ((ux == 0 && uy == 0) || (vx == 0 && vy == 0))
			return {2'b01, 128'd0};
		sat = 1'b0;
		n2 = ux * ux + uy * uy;
		dt = ux * vx + uy * vy;
		cr = ux * vy - uy * vx;
		a = coef_q(dt, n2, sat);
		b = coef_q(cr, n2, sat);
		tx = round_shift((q1x <<< 24) - a * p1x + b * p1y, sat);
		ty = round_shift((q1y <<< 24) - b * p1x - a * p1y, sat);
		return {sat, 1'b0, ty[31:0], tx[31:0], b[31:0], a[31:0]};
	endfunction

	function automatic logic [191:0] points(int p1x, int p1y, int p2x, int p2y,
			int q1x, int q1y, int q2x, int q2y);
		return {q2y[23:0], q2x[23:0], q1y[23:0], q1x[23:0],
			p2y[23:0], p2x[23:0], p1y[23:0], p1x[23:0]};
	endfunction

	task automatic send_points(logic [191:0] d);
		int gap, r;
		@(negedge clk);
		r = $urandom_range(0, 99);
		if (no_gaps || r < 50) gap = 0;
		else if (r < 92) gap = $urandom_range(1, 3);
		else gap = $urandom_range(10, 40);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		transform_q = {transform_q, predict_transform(d)};
		sent++;
	endtask

	task automatic release_line();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic drain();
		release_line();
		wait (transform_q.size() == 0);
	endtask

	task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$error("%s: expected %h, got %h", name, e, a);
			fails++;
		end
	endtask

	always @(negedge clk) begin : ready_driver
		int r, len;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			len = $urandom_range(1, 40);
			m_tready <= 1'b1;
		end else if (r < 93) begin
			len = $urandom_range(1, 3);
			m_tready <= 1'b0;
		end else begin
			len = $urandom_range(15, 60);
			m_tready <= 1'b0;
		end
		repeat (len - 1) @(negedge clk);
	end

	always @(posedge clk) begin : result_check
		logic [129:0] e;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
		if (arst_n && m_tvalid && m_tready) begin
			received++;
			if (transform_q.size() == 0) begin
				$error("result transaction with nothing expected");
				fails++;
			end else begin
				e = transform_q.pop_front();
				if (e[128]) n_coinc++;
				if (e[129]) n_sat++;
				check_field("scale_cos", e[31:0], m_tdata[31:0]);
				check_field("scale_sin", e[63:32], m_tdata[63:32]);
				check_field("shift_x", e[95:64], m_tdata[95:64]);
				check_field("shift_y", e[127:96], m_tdata[127:96]);
				check_field("status", e[128], m_tuser[0]);
				check_field("saturated", e[129], m_tuser[1]);
			end
		end
	end

	task automatic test_extremes();
		send_points(points(-8388608, -8388608, 8388607, 8388607,
			8388607, 8388607, -8388608, -8388608));
		send_points(points(8388607, 8388607, -8388608, -8388608,
			-8388608, -8388608, 8388607, 8388607));
		send_points(points(8388607, -8388608, -8388608, 8388607,
			-8388608, 8388607, 8388607, -8388608));
		send_points(points(0, 0, 256, 0, 0, 0, 256, 0));
		send_points(points(0, 0, 256, 0, 0, 0, 0, 256));
		send_points(points(-1, -1, 0, 0, 8388607, -8388608, 8388606, 8388607));
	endtask

	task automatic test_coincide();
		send_points(points(100, -200, 100, -200, 5, 6, 7, 8));
		send_points(points(1, 2, 3, 4, -77, 99, -77, 99));
		send_points(points(-8388608, 8388607, -8388608, 8388607,
			-8388608, 8388607, -8388608, 8388607));
		send_points(points(0, 0, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_saturation();
		send_points(points(0, 0, 1, 0, -8388608, 0, 8388607, 0));
		send_points(points(0, 0, 0, 1, 0, 8388607, 0, -8388608));
		send_points(points(8388607, 8388607, 8388606, 8388607, 0, 0, 8388607, 8388607));
		send_points(points(-8388608, 8388607, -8388607, 8388607,
			8388607, -8388608, -8388608, 8388607));
		send_points(points(8388607, 0, 8388606, 1, 0, 0, 1, 0));
	endtask

	task automatic test_rounding();
		send_points(points(0, 0, 3, 0, 0, 0, 1, 0));
		send_points(points(0, 0, 3, 0, 0, 0, -1, 0));
		send_points(points(1, 1, 3, 0, 0, 0, 0, -1));
		send_points(points(1, 1, 2, 1, 0, 0, 1, 1));
		send_points(points(-3, 5, -1, 5, 7, 7, 8, 7));
		send_points(points(5, -3, 5, -1, 7, 7, 7, 8));
	endtask

	task automatic test_random(int count);
		int i, r, p1x, p1y, q1x, q1y;
		for (i = 0; i < count; i++) begin
			if (i % 150 == 0) no_gaps = ($urandom_range(0, 3) == 0);
			if (i == count / 2) drain();
			r = $urandom_range(0, 99);
			p1x = $urandom; p1y = $urandom; q1x = $urandom; q1y = $urandom;
			if (r < 40)
				send_points({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
			else if (r < 75)
				send_points(points(p1x, p1y,
					p1x + $urandom_range(0, 64) - 32, p1y + $urandom_range(0, 64) - 32,
					q1x, q1y,
					q1x + $urandom_range(0, 8192) - 4096, q1y + $urandom_range(0, 8192) - 4096));
			else if (r < 90)
				send_points(points(p1x, p1y,
					p1x + $urandom_range(0, 2000) - 1000, p1y + $urandom_range(0, 2000) - 1000,
					q1x, q1y,
					q1x + $urandom_range(0, 2000) - 1000, q1y + $urandom_range(0, 2000) - 1000));
			else if (r < 95)
				send_points(points(p1x, p1y, p1x, p1y, q1x, q1y, $urandom, $urandom));
			else
				send_points(points(p1x, p1y, $urandom, $urandom, q1x, q1y, q1x, q1y));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_extremes();
		test_coincide();
		test_saturation();
		test_rounding();
		test_random(930);
		release_line();
		wait (transform_q.size() == 0);
		repeat (120) @(posedge clk);
		$display("Sent %0d point sets, checked %0d transforms (%0d coincident, %0d clipped).",
			sent, received, n_coinc, n_sat);
		$display("Covered extremes, coincident pairs, clipping, rounding ties, random stalls.");
		if (fails == 0 && transform_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire

[files.f]
src/tpst_pkg.sv
src/tpst_div_cell.sv
src/two_point_similarity_transform_core.sv
test/testbench.sv
